// ----- src/aeag_pkg.sv -----
// Package for the array element address generator.
// Holds sizes, opcodes, item layouts and the write-request structs.
// No dependencies.
`default_nettype none

package aeag_pkg;

  localparam int MAX_ARRAYS = 16;
  localparam int MAX_DIMS   = 10;

  // One memory row per slot: C0 followed by one coefficient per dimension.
  localparam int ROW_LEN    = MAX_DIMS + 1;
  localparam int COEF_DEPTH = MAX_ARRAYS * ROW_LEN;
  localparam int ADDR_W     = $clog2(COEF_DEPTH);
  localparam int CNT_W      = $clog2(MAX_DIMS + 1);
  localparam int DIX_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SIX_W      = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;

  typedef enum logic [1:0] {
    OP_DECLARE = 2'd0,
    OP_BOUND   = 2'd1,
    OP_QUERY   = 2'd2
  } op_t;

  // Input tdata layout, lowest field last.
  typedef struct packed {
    logic signed [31:0] index_value;
    logic signed [31:0] upper_limit;
    logic signed [31:0] lower_limit;
    logic [3:0]         dim_total;
    logic [15:0]        element_bytes;
    logic signed [31:0] base_value;
    logic [3:0]         array_id;
  } in_item_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       data;
  } coef_wr_t;

  typedef struct packed {
    logic             en;
    logic [3:0]       slot;
    logic [CNT_W-1:0] dims;
  } dim_wr_t;

  function automatic logic [ADDR_W-1:0] coef_addr(input logic [3:0] slot,
                                                  input logic [CNT_W-1:0] k);
    return ADDR_W'(int'(slot) * ROW_LEN + int'(k));
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/aeag_coef_seq.sv -----
// Declaration tracking and coefficient setup sequencer.
// Collects the bounds of a declaration and walks the dimensions with one
// shared multiplier, issuing coefficient memory writes. Uses aeag_pkg.
`default_nettype none

module aeag_coef_seq import aeag_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     item_en,
  input  wire op_t      item_op,
  input  wire in_item_t item,
  output logic          busy,
  output coef_wr_t      coef_wr,
  output dim_wr_t       dim_wr
);

  typedef enum logic [1:0] {S_IDLE, S_PROD, S_EXT, S_C0} seq_state_t;

  seq_state_t       state_r;
  logic [3:0]       pend_slot_r;
  logic [31:0]      pend_base_r;
  logic [15:0]      pend_size_r;
  logic [CNT_W-1:0] pend_dims_r;
  logic [CNT_W-1:0] seen_r;
  logic [CNT_W-1:0] k_r;
  logic [31:0]      cur_r;
  logic [31:0]      acc_r;

  logic [31:0] lo_r  [MAX_DIMS];
  logic [31:0] ext_r [MAX_DIMS];

  logic [CNT_W-1:0] dims_sat;
  logic [CNT_W-1:0] seen_inc;
  logic [DIX_W-1:0] kix;
  logic             bound_ok;
  logic [31:0]      mul_b;
  logic [31:0]      prod;

  always_comb begin
    if (int'(item.dim_total) > MAX_DIMS) begin
      dims_sat = CNT_W'(MAX_DIMS);
    end else begin
      dims_sat = CNT_W'(item.dim_total);
    end
  end

  assign seen_inc = seen_r + 1'b1;
  assign kix      = DIX_W'(k_r - 1'b1);
  assign bound_ok = item_en && (item_op == OP_BOUND) && (pend_dims_r != '0) &&
                    (seen_r < pend_dims_r) && (state_r == S_IDLE);

  // The single multiplier takes the lower bound in S_PROD and the extent in S_EXT.
  assign mul_b = (state_r == S_PROD) ? lo_r[kix] : ext_r[kix];
  assign prod  = mul32(cur_r, mul_b);

  // Bound storage keeps the lower bound and the extent of each dimension.
  always_ff @(posedge clk) begin
    if (bound_ok) begin
      lo_r[DIX_W'(seen_r)]  <= item.lower_limit;
      ext_r[DIX_W'(seen_r)] <= item.upper_limit - item.lower_limit + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_slot_r <= '0;
      pend_base_r <= '0;
      pend_size_r <= '0;
      pend_dims_r <= '0;
      seen_r      <= '0;
      k_r         <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (item_en && item_op == OP_DECLARE) begin
            seen_r      <= '0;
            pend_dims_r <= '0;
            if (item.dim_total != '0 && int'(item.array_id) < MAX_ARRAYS) begin
              pend_slot_r <= item.array_id;
              pend_base_r <= item.base_value;
              pend_size_r <= item.element_bytes;
              pend_dims_r <= dims_sat;
            end
          end else if (bound_ok) begin
            seen_r <= seen_inc;
            if (seen_inc == pend_dims_r) begin
              state_r <= S_PROD;
              k_r     <= pend_dims_r;
              cur_r   <= 32'(pend_size_r);
              acc_r   <= pend_base_r;
            end
          end
        end
        S_PROD: begin
          acc_r <= acc_r - prod;
          if (k_r == CNT_W'(1)) begin
            state_r <= S_C0;
          end else begin
            state_r <= S_EXT;
          end
        end
        S_EXT: begin
          cur_r   <= prod;
          k_r     <= k_r - 1'b1;
          state_r <= S_PROD;
        end
        S_C0: begin
          state_r     <= S_IDLE;
          pend_dims_r <= '0;
          seen_r      <= '0;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    coef_wr.en   = (state_r == S_PROD) || (state_r == S_C0);
    coef_wr.addr = coef_addr(pend_slot_r, (state_r == S_PROD) ? k_r : '0);
    coef_wr.data = (state_r == S_PROD) ? cur_r : acc_r;
    dim_wr.en    = (state_r == S_C0);
    dim_wr.slot  = pend_slot_r;
    dim_wr.dims  = pend_dims_r;
  end

endmodule

`default_nettype wire

// ----- src/array_element_address_generator.sv -----
// Top level of the row-major array element address generator.
// Depends on aeag_pkg and aeag_coef_seq.
//
// Input channel in_*: one transaction per declare, bound or query-index item.
// in_tuser carries the opcode; in_tdata carries the item fields.
// Output channel out_*: one transaction per completed query, carrying the
// element address and slot, with out_tuser flagging an undeclared slot.
//
// Timing: a query-index item has the coefficient memory read in the accept
// cycle and the multiply-accumulate run in the next. The last bound of a
// declaration starts the coefficient setup, which holds in_tready low while
// it runs, since one multiplier serves both the coefficient chain and the
// lower-bound correction, one product per cycle.
// A result sits in an output register; while it waits, the block keeps
// taking declare and bound items and index items that do not end a query.
// An index item that ends a query waits in the multiply-accumulate state
// until the register is free. Reset clears the declared-slot table and all
// control state; coefficient memory contents are left as they are.
`default_nettype none

module array_element_address_generator import aeag_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // in_tdata, from bit 0: array_id(4), base_value(32), element_bytes(16),
  // dim_total(4), lower_limit(32), upper_limit(32), index_value(32)
  input  wire logic [151:0] in_tdata,
  // in_tuser, from bit 0: op(2)
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_tdata, from bit 0: element_address(32), result_id(4), zero fill(4)
  output logic [39:0]       out_tdata,
  // out_tuser, from bit 0: undeclared(1)
  output logic [0:0]        out_tuser
);

  typedef enum logic {Q_IDLE, Q_MAC} q_state_t;

  in_item_t item;
  op_t      item_op;
  logic     in_fire;
  logic     seq_busy;
  coef_wr_t coef_wr;
  dim_wr_t  dim_wr;

  q_state_t         state_r;
  logic [3:0]       qslot_r;
  logic [CNT_W-1:0] pos_r;
  logic [31:0]      sum_r;
  logic [31:0]      idx_r;
  logic             first_r;
  logic             out_valid_r;
  logic [31:0]      out_addr_r;
  logic [3:0]       out_id_r;
  logic             out_undecl_r;

  logic [CNT_W-1:0] dct_r [MAX_ARRAYS];
  logic [31:0]      coef_mem [COEF_DEPTH];
  logic [31:0]      rd_c0_r;
  logic [31:0]      rd_ck_r;

  logic [3:0]       acc_slot;
  logic [CNT_W-1:0] pos_inc;
  logic [CNT_W-1:0] q_dims;
  logic [31:0]      mac_base;
  logic [31:0]      mac_sum;
  logic             emit;
  logic             out_free;
  logic             mac_go;

  assign item    = in_item_t'(in_tdata);
  assign item_op = op_t'(in_tuser);
  assign in_tready = (state_r == Q_IDLE) && !seq_busy;
  assign in_fire   = in_tvalid && in_tready;

  aeag_coef_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .item_en (in_fire),
    .item_op (item_op),
    .item    (item),
    .busy    (seq_busy),
    .coef_wr (coef_wr),
    .dim_wr  (dim_wr)
  );

  // The first index of a query names the slot; later ones follow it.
  assign acc_slot = (pos_r == '0) ? item.array_id : qslot_r;
  assign pos_inc  = pos_r + 1'b1;

  // The read data must hold through a stalled multiply-accumulate cycle.
  always_ff @(posedge clk) begin
    if (coef_wr.en) begin
      coef_mem[coef_wr.addr] <= coef_wr.data;
    end
    if (in_fire && item_op == OP_QUERY) begin
      rd_c0_r <= coef_mem[coef_addr(acc_slot, '0)];
      rd_ck_r <= coef_mem[coef_addr(acc_slot, pos_inc)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < MAX_ARRAYS; s++) begin
        dct_r[s] <= '0;
      end
    end else if (dim_wr.en) begin
      dct_r[SIX_W'(dim_wr.slot)] <= dim_wr.dims;
    end
  end

  always_comb begin
    if (int'(qslot_r) < MAX_ARRAYS) begin
      q_dims = dct_r[SIX_W'(qslot_r)];
    end else begin
      q_dims = '0;
    end
    mac_base = first_r ? rd_c0_r : sum_r;
    // A count that dropped mid-query adds nothing and ends the query.
    if (pos_r < q_dims) begin
      mac_sum = mac_base + mul32(rd_ck_r, idx_r);
    end else begin
      mac_sum = mac_base;
    end
    emit     = (q_dims == '0) || (pos_inc >= q_dims);
    out_free = !out_valid_r || out_tready;
    mac_go   = (state_r == Q_MAC) && (!emit || out_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= Q_IDLE;
      qslot_r     <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && !(mac_go && emit)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        Q_IDLE: begin
          if (in_fire && item_op == OP_QUERY) begin
            qslot_r <= acc_slot;
            first_r <= (pos_r == '0);
            idx_r   <= item.index_value;
            state_r <= Q_MAC;
          end
        end
        Q_MAC: begin
          if (mac_go) begin
            state_r <= Q_IDLE;
            if (q_dims == '0) begin
              pos_r        <= '0;
              sum_r        <= '0;
              out_valid_r  <= 1'b1;
              out_addr_r   <= '0;
              out_id_r     <= qslot_r;
              out_undecl_r <= 1'b1;
            end else begin
              sum_r <= mac_sum;
              if (emit) begin
                pos_r        <= '0;
                out_valid_r  <= 1'b1;
                out_addr_r   <= mac_sum;
                out_id_r     <= qslot_r;
                out_undecl_r <= 1'b0;
              end else begin
                pos_r <= pos_inc;
              end
            end
          end
        end
        default: state_r <= Q_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_id_r, out_addr_r};
  assign out_tuser  = out_undecl_r;

endmodule

`default_nettype wire

// ----- src/aeag_checker.sv -----
// Port-level checker for the array element address generator.
// Depends on aeag_pkg; bound to the top level below.
`default_nettype none

module aeag_checker import aeag_pkg::*; (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic [151:0] in_tdata,
  input wire logic [1:0]   in_tuser,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [39:0]  out_tdata,
  input wire logic [0:0]   out_tuser
);

  // A stalled result must hold its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An undeclared slot always reports address zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[31:0] == 32'd0)
    else $error("undeclared result with nonzero address");

  // A query index occupies the multiply-accumulate cycle after it.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_QUERY |=> !in_tready)
    else $error("input accepted during multiply-accumulate");

  // Nothing is offered right after reset.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Upper fill bits stay zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:36] == 4'd0)
    else $error("nonzero fill bits in result");

endmodule

bind array_element_address_generator aeag_checker u_aeag_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- tb/sv/array_element_address_generator_tb.sv -----
// Testbench for the row-major array element address generator.
// Drives declare, bound and query-index transactions and checks every address against a plan
// value or its array-table model. Depends on aeag_pkg and array_element_address_generator.
`default_nettype none

module array_element_address_generator_tb;
  import aeag_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_GOAL  = 1750;
  localparam int QUIET_FROM = 1500;
  localparam int DRAIN_CYCLES = 40;
  localparam int PLAN_ROWS = 25;

  typedef struct packed {
    logic [31:0] addr;
    logic [3:0]  slot;
    logic        undeclared;
  } addr_result_t;

  // a is the base, the lower bound or the index, depending on op; b is the upper bound.
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  id;
    logic [31:0] a;
    logic [31:0] b;
    logic [15:0] size;
    logic [3:0]  dims;
    logic        typed;
    logic [31:0] exp_addr;
    logic        exp_undeclared;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{OP_QUERY,   4'd3, 32'd0,        32'd0,        16'd0,      4'd0,  1'b1, 32'd0,        1'b1},
    '{OP_UNUSED,  4'd5, 32'd0,        32'd0,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_DECLARE, 4'd0, 32'd1000,     32'd0,        16'd4,      4'd1,  1'b0, 32'd0,        1'b0},
    '{OP_BOUND,   4'd0, 32'd0,        32'd9,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_QUERY,   4'd0, 32'd5,        32'd0,        16'd0,      4'd0,  1'b1, 32'd1020,     1'b0},
    '{OP_QUERY,   4'd0, 32'h80000000, 32'd0,        16'd0,      4'd0,  1'b1, 32'd1000,     1'b0},
    // The old entry must answer until the new declaration gets its last bound.
    '{OP_DECLARE, 4'd0, 32'd0,        32'd0,        16'd2,      4'd1,  1'b0, 32'd0,        1'b0},
    '{OP_QUERY,   4'd0, 32'd1,        32'd0,        16'd0,      4'd0,  1'b1, 32'd1004,     1'b0},
    '{OP_BOUND,   4'd0, 32'd0,        32'd0,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_QUERY,   4'd0, 32'hFFFFFFFF, 32'd0,        16'd0,      4'd0,  1'b1, 32'hFFFFFFFE, 1'b0},
    // A zero-dimension declare cancels the unfinished one, so the next bound is stray.
    '{OP_DECLARE, 4'd1, 32'h80000000, 32'd0,        16'hFFFF,   4'd2,  1'b0, 32'd0,        1'b0},
    '{OP_BOUND,   4'd1, 32'h80000000, 32'h7FFFFFFF, 16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_DECLARE, 4'd1, 32'd0,        32'd0,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_BOUND,   4'd1, 32'd1,        32'd2,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_QUERY,   4'd1, 32'd7,        32'd0,        16'd0,      4'd0,  1'b1, 32'd0,        1'b1},
    '{OP_DECLARE, 4'd2, 32'hFFFFFFFF, 32'd0,        16'd0,      4'd2,  1'b0, 32'd0,        1'b0},
    '{OP_DECLARE, 4'd2, 32'h7FFFFFFF, 32'd0,        16'hFFFF,   4'd2,  1'b0, 32'd0,        1'b0},
    '{OP_BOUND,   4'd2, 32'h80000000, 32'h7FFFFFFF, 16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_BOUND,   4'd2, 32'h7FFFFFFF, 32'h80000000, 16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_QUERY,   4'd2, 32'h7FFFFFFF, 32'd0,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_QUERY,   4'd2, 32'h80000000, 32'd0,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    // Slot 2 shrinks to one dimension while a query on it has taken one index.
    '{OP_QUERY,   4'd2, 32'd3,        32'd0,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_DECLARE, 4'd2, 32'd0,        32'd0,        16'd8,      4'd1,  1'b0, 32'd0,        1'b0},
    '{OP_BOUND,   4'd2, 32'd0,        32'd3,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0},
    '{OP_QUERY,   4'd2, 32'd9,        32'd0,        16'd0,      4'd0,  1'b0, 32'd0,        1'b0}
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b1;
  logic [39:0]  out_tdata;
  logic [0:0]   out_tuser;

  array_element_address_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the array table and of the declaration and query in progress.
  logic [31:0] coef [MAX_ARRAYS][MAX_DIMS + 1];
  int unsigned dim_count [MAX_ARRAYS];
  logic [31:0] pend_lo [MAX_DIMS];
  logic [31:0] pend_hi [MAX_DIMS];
  logic [3:0]  pend_slot = '0;
  logic [31:0] pend_base = '0;
  logic [15:0] pend_size = '0;
  int unsigned pend_dims = 0;
  int unsigned bounds_taken = 0;
  logic [3:0]  query_slot = '0;
  int unsigned query_pos = 0;
  logic [31:0] query_sum = '0;

  addr_result_t address_q [$];
  addr_result_t want;
  int mismatches = 0;
  int fed = 0;
  int gap_odds = 20;
  int stall_odds = 20;
  int stall_left = 0;

  initial begin
    foreach (dim_count[s]) dim_count[s] = 0;
  end

  task automatic model_item(input logic [1:0] op, input in_item_t it,
                            output bit fires, output addr_result_t res);
    int unsigned d;
    logic [31:0] c0;
    fires = 1'b0;
    res = '0;
    case (op)
      OP_DECLARE: begin
        d = it.dim_total;
        pend_dims = 0;
        bounds_taken = 0;
        if (d != 0) begin
          if (d > MAX_DIMS) d = MAX_DIMS;
          pend_slot = it.array_id;
          pend_base = it.base_value;
          pend_size = it.element_bytes;
          pend_dims = d;
        end
      end
      OP_BOUND: begin
        if (pend_dims != 0 && bounds_taken < pend_dims) begin
          pend_lo[bounds_taken] = it.lower_limit;
          pend_hi[bounds_taken] = it.upper_limit;
          bounds_taken++;
          if (bounds_taken == pend_dims) begin
            coef[pend_slot][pend_dims] = {16'h0, pend_size};
            for (int k = pend_dims - 1; k >= 1; k--)
              coef[pend_slot][k] = coef[pend_slot][k + 1] * (pend_hi[k] - pend_lo[k] + 32'd1);
            c0 = pend_base;
            for (int k = 1; k <= pend_dims; k++)
              c0 = c0 - coef[pend_slot][k] * pend_lo[k - 1];
            coef[pend_slot][0] = c0;
            dim_count[pend_slot] = pend_dims;
            pend_dims = 0;
            bounds_taken = 0;
          end
        end
      end
      OP_QUERY: begin
        if (query_pos == 0) query_slot = it.array_id;
        d = dim_count[query_slot];
        if (d == 0) begin
          query_pos = 0;
          query_sum = '0;
          fires = 1'b1;
          res.slot = query_slot;
          res.undeclared = 1'b1;
        end else begin
          if (query_pos == 0) query_sum = coef[query_slot][0];
          if (query_pos < d)
            query_sum = query_sum + coef[query_slot][query_pos + 1] * it.index_value;
          query_pos++;
          if (query_pos >= d) begin
            query_pos = 0;
            fires = 1'b1;
            res.addr = query_sum;
            res.slot = query_slot;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send(input logic [1:0] op, input in_item_t it,
                      input bit typed, input addr_result_t typed_res);
    bit fires;
    addr_result_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= it;
    do @(posedge clk); while (!in_tready);
    model_item(op, it, fires, res);
    if (typed) address_q = {address_q, typed_res};
    else if (fires) address_q = {address_q, res};
    if (op != OP_UNUSED) fed++;
  endtask

  task automatic source_gap();
    if ($urandom_range(0, 99) < gap_odds) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Every field filled with noise; callers overwrite the ones the op uses.
  function automatic in_item_t scrambled_item();
    logic [159:0] noise;
    noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return noise[151:0];
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return 32'($urandom_range(0, 40)) - 32'd20;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_declare(input logic [3:0] slot, input logic [3:0] dims);
    in_item_t it;
    it = scrambled_item();
    it.array_id = slot;
    it.dim_total = dims;
    it.base_value = pick_word();
    it.element_bytes = $urandom_range(0, 1) ? 16'($urandom_range(1, 16)) : 16'($urandom());
    send(OP_DECLARE, it, 1'b0, '0);
  endtask

  task automatic send_bound();
    in_item_t it;
    it = scrambled_item();
    it.lower_limit = pick_word();
    it.upper_limit = $urandom_range(0, 1) ? it.lower_limit + 32'($urandom_range(0, 7))
                                          : pick_word();
    send(OP_BOUND, it, 1'b0, '0);
  endtask

  task automatic send_index(input logic [3:0] slot);
    in_item_t it;
    it = scrambled_item();
    it.array_id = slot;
    it.index_value = $urandom_range(0, 1) ? 32'($urandom_range(0, 7)) : pick_word();
    send(OP_QUERY, it, 1'b0, '0);
  endtask

  // Result channel back-pressure in random bursts.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 99) < stall_odds) begin
      stall_left <= $urandom_range(1, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic note_mismatch(input string what, input addr_result_t exp_res);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected addr %h id %0d undeclared %0b, got addr %h id %0d undeclared %0b",
               what, exp_res.addr, exp_res.slot, exp_res.undeclared,
               out_tdata[31:0], out_tdata[35:32], out_tuser[0]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (address_q.size() == 0) begin
        note_mismatch("address transaction with none expected", '0);
      end else begin
        want = address_q.pop_front();
        if (out_tdata[31:0] !== want.addr || out_tdata[35:32] !== want.slot ||
            out_tuser[0] !== want.undeclared)
          note_mismatch("address mismatch", want);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL array_element_address_generator");
    $finish;
  end

  initial begin
    in_item_t it;
    addr_result_t typed_res;
    int phase;
    int dims;
    int n;
    logic [3:0] slot;
    phase = -1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PLAN[r]) begin
      it = '0;
      it.array_id = PLAN[r].id;
      case (PLAN[r].op)
        OP_DECLARE: begin
          it.base_value = PLAN[r].a;
          it.element_bytes = PLAN[r].size;
          it.dim_total = PLAN[r].dims;
        end
        OP_BOUND: begin
          it.lower_limit = PLAN[r].a;
          it.upper_limit = PLAN[r].b;
        end
        default: it.index_value = PLAN[r].a;
      endcase
      typed_res.addr = PLAN[r].exp_addr;
      typed_res.slot = PLAN[r].id;
      typed_res.undeclared = PLAN[r].exp_undeclared;
      send(PLAN[r].op, it, PLAN[r].typed, typed_res);
      source_gap();
    end

    while (fed < ITEM_GOAL) begin
      if (fed >= QUIET_FROM) begin
        gap_odds = 0;
        stall_odds = 0;
      end else if (fed / 250 != phase) begin
        phase = fed / 250;
        gap_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 50);
        stall_odds = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 50);
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // A declaration, usually complete, sometimes with more dimensions than fit.
          slot = $urandom_range(0, 15);
          case ($urandom_range(0, 9))
            0: dims = $urandom_range(5, 10);
            1: dims = $urandom_range(11, 15);
            default: dims = $urandom_range(1, 4);
          endcase
          send_declare(slot, 4'(dims));
          source_gap();
          if (dims > MAX_DIMS) dims = MAX_DIMS;
          for (int j = 0; j < dims; j++) begin
            if ($urandom_range(0, 49) == 0) break;
            send_bound();
            source_gap();
          end
        end
        3, 4, 5, 6, 7, 8: begin
          // A whole query, now and then with a declaration item slipped in between indices.
          slot = $urandom_range(0, 15);
          n = (dim_count[slot] == 0) ? 1 : dim_count[slot];
          for (int j = 0; j < n; j++) begin
            send_index(j == 0 ? slot : 4'($urandom()));
            source_gap();
            if ($urandom_range(0, 39) == 0) begin
              if ($urandom_range(0, 1)) send_declare(4'($urandom()), 4'($urandom_range(1, 3)));
              else send_bound();
            end
          end
        end
        default: begin
          case ($urandom_range(0, 3))
            0: send(OP_UNUSED, scrambled_item(), 1'b0, '0);
            1: send_bound();
            2: send_declare(4'($urandom()), 4'd0);
            default: send_index(4'($urandom()));
          endcase
          source_gap();
        end
      endcase
    end

    in_tvalid <= 1'b0;
    while (address_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && address_q.size() == 0) begin
      $display("PASS array_element_address_generator");
    end else begin
      $display("FAIL array_element_address_generator");
    end
    $finish;
  end

endmodule

`default_nettype wire
